[hdl/hmib_pkg.sv]
// ----------------------------------------------------------------------------
// hmib_pkg
// Shared types, constants and byte-selection helpers for the HDR mastering
// infoframe builder.
// ----------------------------------------------------------------------------
package hmib_pkg;

  localparam int GAMUT_COUNT = 6;

  localparam logic [4:0] LAST_POS   = 5'd29;
  localparam logic [4:0] CKSUM_POS  = 5'd3;
  localparam logic [4:0] CHROMA_POS = 5'd6;
  localparam logic [4:0] LUMA_POS   = 5'd22;

  localparam logic [7:0] HDR_TYPE    = 8'h87;
  localparam logic [7:0] HDR_VERSION = 8'h01;
  localparam logic [7:0] HDR_LENGTH  = 8'h1A;
  localparam logic [7:0] META_TYPE   = 8'h00;

  // green x/y, blue x/y, red x/y, white x/y; coordinate * 50000
  localparam logic [15:0] CHROMA_TABLE [GAMUT_COUNT][8] = '{
    '{16'd15000, 16'd30000, 16'd7500, 16'd3000, 16'd32000, 16'd16500, 16'd15635, 16'd16450},
    '{16'd8500,  16'd39850, 16'd6550, 16'd2300, 16'd35400, 16'd14600, 16'd15635, 16'd16450},
    '{16'd13250, 16'd34500, 16'd7500, 16'd3000, 16'd34000, 16'd16000, 16'd15635, 16'd16450},
    '{16'd13250, 16'd34500, 16'd7500, 16'd3000, 16'd34000, 16'd16000, 16'd15700, 16'd17550},
    '{16'd13250, 16'd34500, 16'd7500, 16'd3000, 16'd34000, 16'd16000, 16'd16084, 16'd16884},
    '{16'd13030, 16'd33660, 16'd7210, 16'd2560, 16'd33515, 16'd16485, 16'd15635, 16'd16450}
  };

  typedef struct packed {
    logic [2:0]  eotf;
    logic [2:0]  gamut;
    logic [15:0] peak_lum;
    logic [15:0] black_lum;
    logic [15:0] max_cll;
    logic [15:0] avg_lum;
  } req_t;

  typedef struct packed {
    req_t       req;
    logic [7:0] cksum;
  } frame_t;

  // Unlisted gamut indexes read as zero chromaticities.
  function automatic logic [15:0] chroma_value(logic [2:0] gamut, logic [2:0] k);
    logic [15:0] v;
    v = 16'd0;
    if (int'(gamut) < GAMUT_COUNT) begin
      v = CHROMA_TABLE[gamut][k];
    end
    return v;
  endfunction

  // Byte sum (mod 256) of the sixteen chromaticity bytes; constant per gamut.
  function automatic logic [7:0] chroma_sum(logic [2:0] gamut);
    logic [7:0]  s;
    logic [15:0] v;
    s = 8'd0;
    for (int k = 0; k < 8; k++) begin
      v = chroma_value(gamut, 3'(k));
      s = s + v[7:0] + v[15:8];
    end
    return s;
  endfunction

  // Byte of the frame at a given position; 16-bit words are little-endian.
  function automatic logic [7:0] frame_byte_at(frame_t f, logic [4:0] pos);
    logic [7:0]  b;
    logic [15:0] word;
    logic [4:0]  rel;
    b    = 8'h00;
    word = 16'd0;
    rel  = 5'd0;
    priority if (pos < CHROMA_POS) begin
      case (pos[2:0])
        3'd0:    b = HDR_TYPE;
        3'd1:    b = HDR_VERSION;
        3'd2:    b = HDR_LENGTH;
        3'd3:    b = f.cksum;
        3'd4:    b = {5'd0, f.req.eotf};
        3'd5:    b = META_TYPE;
        default: b = 8'h00;
      endcase
    end else if (pos < LUMA_POS) begin
      rel  = pos - CHROMA_POS;
      word = chroma_value(f.req.gamut, rel[3:1]);
      b    = pos[0] ? word[15:8] : word[7:0];
    end else begin
      rel = pos - LUMA_POS;
      unique case (rel[2:1])
        2'd0: word = f.req.peak_lum;
        2'd1: word = f.req.black_lum;
        2'd2: word = f.req.max_cll;
        2'd3: word = f.req.avg_lum;
      endcase
      b = pos[0] ? word[15:8] : word[7:0];
    end
    return b;
  endfunction

endpackage

[hdl/hmib_channels.sv]
// ----------------------------------------------------------------------------
// hmib channels
// Valid/ready channel interfaces: request in, infoframe bytes out.
// ----------------------------------------------------------------------------
interface hmib_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  eotf;
  logic [2:0]  gamut;
  logic [15:0] peak_lum;
  logic [15:0] black_lum;
  logic [15:0] max_cll;
  logic [15:0] avg_lum;

  modport source (output valid, eotf, gamut, peak_lum, black_lum, max_cll, avg_lum,
                  input ready);
  modport sink   (input valid, eotf, gamut, peak_lum, black_lum, max_cll, avg_lum,
                  output ready);
endinterface

interface hmib_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic [4:0] byte_position;
  logic       last;

  modport source (output valid, frame_byte, byte_position, last, input ready);
  modport sink   (input valid, frame_byte, byte_position, last, output ready);
endinterface

[hdl/hmib_checksum.sv]
// ----------------------------------------------------------------------------
// hmib_checksum
// Infoframe checksum: two's complement of the byte sum of the whole frame
// taken with the checksum byte at zero.
// ----------------------------------------------------------------------------
module hmib_checksum (
  input  hmib_pkg::req_t req,
  output logic [7:0]     cksum
);
  import hmib_pkg::*;

  logic [7:0] sum;

  always_comb begin
    sum = HDR_TYPE + HDR_VERSION + HDR_LENGTH + META_TYPE + {5'd0, req.eotf}
        + chroma_sum(req.gamut)
        + req.peak_lum[7:0]  + req.peak_lum[15:8]
        + req.black_lum[7:0] + req.black_lum[15:8]
        + req.max_cll[7:0]   + req.max_cll[15:8]
        + req.avg_lum[7:0]   + req.avg_lum[15:8];
    cksum = 8'd0 - sum;
  end

endmodule

[hdl/hmib_serializer.sv]
// ----------------------------------------------------------------------------
// hmib_serializer
// Holds the frame in flight and sends it one byte per transaction through a
// registered output stage.
// ----------------------------------------------------------------------------
module hmib_serializer (
  input  logic              clk,
  input  logic              rst,
  input  logic              load_valid,
  output logic              load_ready,
  input  hmib_pkg::frame_t  load_frame,
  hmib_byte_if.source       out
);
  import hmib_pkg::*;

  frame_t     cur;
  logic       busy;
  logic [4:0] pos;
  logic       emit;
  logic       done;
  logic       load;

  assign emit       = busy && (!out.valid || out.ready);
  assign done       = emit && (pos == LAST_POS);
  assign load_ready = !busy || done;
  assign load       = load_valid && load_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      pos       <= 5'd0;
      out.valid <= 1'b0;
    end else begin
      if (emit) begin
        out.valid <= 1'b1;
      end else if (out.ready) begin
        out.valid <= 1'b0;
      end
      if (load) begin
        busy <= 1'b1;
        pos  <= 5'd0;
      end else if (done) begin
        busy <= 1'b0;
      end else if (emit) begin
        pos <= pos + 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cur <= load_frame;
    end
    if (emit) begin
      out.frame_byte    <= frame_byte_at(cur, pos);
      out.byte_position <= pos;
      out.last          <= (pos == LAST_POS);
    end
  end

`ifndef NO_ASSERTIONS
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> pos <= LAST_POS)
    else $error("byte position ran past the frame end");

  a_last_pos: assert property (@(posedge clk) disable iff (rst)
    out.valid && out.last |-> out.byte_position == LAST_POS)
    else $error("last flag on wrong byte");

  a_header: assert property (@(posedge clk) disable iff (rst)
    out.valid && out.byte_position == 5'd0 |-> out.frame_byte == HDR_TYPE)
    else $error("frame does not start with the type code");

  a_keep_busy: assert property (@(posedge clk) disable iff (rst)
    emit && pos != LAST_POS |=> busy && pos == $past(pos) + 5'd1)
    else $error("frame dropped before its last byte");
`endif

endmodule

[hdl/hdr_mastering_infoframe_builder.sv]
// ----------------------------------------------------------------------------
// hdr_mastering_infoframe_builder
// Builds the 30-byte HDR dynamic range and mastering infoframe from one
// request and streams it out one byte per transaction.
// ----------------------------------------------------------------------------
// Each accepted request produces exactly 30 byte transactions, positions 0 to
// 29, with last set on position 29: header 87 01 1A, checksum, EOTF, metadata
// type 0, the eight chromaticities of the selected gamut (zero for indexes 6
// and 7), then peak_lum, black_lum, max_cll and avg_lum, all 16-bit values
// little-endian. An accepted request passes through the input register, the
// frame register and the registered output stage before its first byte is
// valid. The output port sends one byte per cycle while frame.ready is high;
// consecutive frames go out back to back with no gap, because the next
// request waits in the input register while the current frame streams and
// is loaded on the cycle its last byte is issued. The checksum is formed
// when a request moves from the input register into the frame register.
// ----------------------------------------------------------------------------
module hdr_mastering_infoframe_builder (
  input  logic         clk,
  input  logic         rst,
  hmib_req_if.sink     req,
  hmib_byte_if.source  frame
);
  import hmib_pkg::*;

  // Input register: one pending request.
  logic   req_valid;
  req_t   req_data;
  logic   load_ready;
  logic [7:0] cksum;
  frame_t load_frame;

  assign req.ready = !req_valid || load_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (req.valid && req.ready) begin
      req_valid <= 1'b1;
    end else if (load_ready) begin
      req_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      req_data.eotf      <= req.eotf;
      req_data.gamut     <= req.gamut;
      req_data.peak_lum  <= req.peak_lum;
      req_data.black_lum <= req.black_lum;
      req_data.max_cll   <= req.max_cll;
      req_data.avg_lum   <= req.avg_lum;
    end
  end

  // Checksum over the pending request.
  hmib_checksum u_checksum (
    .req   (req_data),
    .cksum (cksum)
  );

  assign load_frame.req   = req_data;
  assign load_frame.cksum = cksum;

  // Frame register, position counter and output stage.
  hmib_serializer u_serializer (
    .clk        (clk),
    .rst        (rst),
    .load_valid (req_valid),
    .load_ready (load_ready),
    .load_frame (load_frame),
    .out        (frame)
  );

endmodule
